// ----- hdl/lsd_pkg.sv -----
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared types and constants for the lidar obstacle steering detector.
// ----------------------------------------------------------------------------
package lsd_pkg;

  localparam int CoordW    = 16;
  localparam int MagW      = 15;
  localparam int AddrW     = 5;
  localparam int DataW     = 32;
  localparam int QDepthDef = 4;

  localparam logic [2:0] RegNearMinX     = 3'd0;
  localparam logic [2:0] RegNearMaxX     = 3'd1;
  localparam logic [2:0] RegFarMinX      = 3'd2;
  localparam logic [2:0] RegFloorZ       = 3'd3;
  localparam logic [2:0] RegSteerMag     = 3'd4;

  localparam logic signed [CoordW-1:0] NearMinXRst = 16'sd768;
  localparam logic signed [CoordW-1:0] NearMaxXRst = 16'sd3840;
  localparam logic signed [CoordW-1:0] FarMinXRst  = 16'sd4096;
  localparam logic signed [CoordW-1:0] FloorZRst   = -16'sd128;
  localparam logic [MagW-1:0]          SteerMagRst = 15'd12861;

  typedef struct packed {
    logic signed [CoordW-1:0] near_min_x;
    logic signed [CoordW-1:0] near_max_x;
    logic signed [CoordW-1:0] far_min_x;
    logic signed [CoordW-1:0] floor_z;
    logic [MagW-1:0]          steer_magnitude;
  } lsd_cfg_t;

  typedef struct packed {
    logic                     near_ok;
    logic                     far_ok;
    logic signed [CoordW-1:0] y;
    logic                     last;
  } lsd_item_t;

endpackage

// ----- hdl/lsd_point_if.sv -----
// ----------------------------------------------------------------------------
// lsd_point_if
// Valid/ready channel carrying one lidar point per transaction.
// ----------------------------------------------------------------------------
interface lsd_point_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;
  logic               frame_last;

  modport source (output valid, point_x, point_y, point_z, frame_last, input ready);
  modport sink   (input valid, point_x, point_y, point_z, frame_last, output ready);
endinterface

// ----- hdl/lsd_steer_if.sv -----
// ----------------------------------------------------------------------------
// lsd_steer_if
// Valid/ready channel carrying one steering command per transaction.
// ----------------------------------------------------------------------------
interface lsd_steer_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] steer_value;
  logic               obstacle_now;

  modport source (output valid, steer_value, obstacle_now, input ready);
  modport sink   (input valid, steer_value, obstacle_now, output ready);
endinterface

// ----- hdl/lsd_regs.sv -----
// ----------------------------------------------------------------------------
// lsd_regs
// APB-style configuration registers for thresholds and steering magnitude.
// ----------------------------------------------------------------------------
module lsd_regs
  import lsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output lsd_cfg_t         cfg
);

  lsd_cfg_t   cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near_min_x      <= NearMinXRst;
      cfg_r.near_max_x      <= NearMaxXRst;
      cfg_r.far_min_x       <= FarMinXRst;
      cfg_r.floor_z         <= FloorZRst;
      cfg_r.steer_magnitude <= SteerMagRst;
    end else if (wr_en) begin
      case (idx)
        RegNearMinX: cfg_r.near_min_x      <= pwdata[CoordW-1:0];
        RegNearMaxX: cfg_r.near_max_x      <= pwdata[CoordW-1:0];
        RegFarMinX:  cfg_r.far_min_x       <= pwdata[CoordW-1:0];
        RegFloorZ:   cfg_r.floor_z         <= pwdata[CoordW-1:0];
        RegSteerMag: cfg_r.steer_magnitude <= pwdata[MagW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegNearMinX: prdata = DataW'(cfg_r.near_min_x);
      RegNearMaxX: prdata = DataW'(cfg_r.near_max_x);
      RegFarMinX:  prdata = DataW'(cfg_r.far_min_x);
      RegFloorZ:   prdata = DataW'(cfg_r.floor_z);
      RegSteerMag: prdata = DataW'(cfg_r.steer_magnitude);
      default:     prdata = '0;
    endcase
  end

endmodule

// ----- hdl/lsd_front.sv -----
// ----------------------------------------------------------------------------
// lsd_front
// Accepts points and classifies them against the near and far windows.
// ----------------------------------------------------------------------------
module lsd_front
  import lsd_pkg::*;
(
  input  lsd_cfg_t    cfg,
  lsd_point_if.sink   in_pt,
  output logic        push_valid,
  output lsd_item_t   push_item,
  input  logic        push_ready
);

  logic above_floor;

  assign above_floor  = in_pt.point_z > cfg.floor_z;
  assign in_pt.ready  = push_ready;
  assign push_valid   = in_pt.valid;

  always_comb begin
    push_item.near_ok = above_floor && (in_pt.point_x > cfg.near_min_x)
                        && (in_pt.point_x < cfg.near_max_x);
    push_item.far_ok  = above_floor && (in_pt.point_x > cfg.far_min_x);
    push_item.y       = in_pt.point_y;
    push_item.last    = in_pt.frame_last;
  end

endmodule

// ----- hdl/lsd_fifo.sv -----
// ----------------------------------------------------------------------------
// lsd_fifo
// Short queue of classified points between the front and back parts.
// ----------------------------------------------------------------------------
module lsd_fifo
  import lsd_pkg::*;
#(
  parameter int QDepth = QDepthDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  lsd_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output lsd_item_t pop_item
);

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  lsd_item_t       mem [QDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r;
  logic            push, pop;

  assign push_ready = count_r != CntW'(QDepth);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(QDepth))
    else $error("queue count exceeds depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow a lone push");

endmodule

// ----- hdl/lsd_back.sv -----
// ----------------------------------------------------------------------------
// lsd_back
// Folds points into per-frame state and issues steering commands.
// ----------------------------------------------------------------------------
module lsd_back
  import lsd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic [MagW-1:0] steer_magnitude,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  lsd_item_t       pop_item,
  lsd_steer_if.source     out_st
);

  logic                     near_r, near_nxt;
  logic signed [CoordW-1:0] max_r, max_nxt;
  logic signed [CoordW-1:0] min_r, min_nxt;
  logic                     latched_r;
  logic                     out_valid_r;
  logic signed [CoordW-1:0] steer_r;
  logic                     obstacle_r;
  logic                     pop_fire;
  logic                     emit_on, emit_off;
  logic [CoordW:0]          max_mag, min_mag;
  logic [CoordW-1:0]        steer_nxt;

  assign pop_ready = !out_valid_r || out_st.ready;
  assign pop_fire  = pop_valid && pop_ready;

  assign near_nxt = near_r || pop_item.near_ok;
  assign max_nxt  = (pop_item.far_ok && (pop_item.y > max_r)) ? pop_item.y : max_r;
  assign min_nxt  = (pop_item.far_ok && (pop_item.y < min_r)) ? pop_item.y : min_r;

  assign emit_on  = near_nxt && !latched_r;
  assign emit_off = !near_nxt && latched_r;

  // The maximum never drops below zero and the minimum never rises above it.
  assign max_mag   = {1'b0, max_nxt};
  assign min_mag   = (CoordW + 1)'(0) - {min_nxt[CoordW-1], min_nxt};
  assign steer_nxt = (max_mag > min_mag) ? {1'b0, steer_magnitude}
                                         : CoordW'(0) - {1'b0, steer_magnitude};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r      <= 1'b0;
      max_r       <= '0;
      min_r       <= '0;
      latched_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop_fire) begin
        if (pop_item.last) begin
          near_r    <= 1'b0;
          max_r     <= '0;
          min_r     <= '0;
          latched_r <= near_nxt;
        end else begin
          near_r <= near_nxt;
          max_r  <= max_nxt;
          min_r  <= min_nxt;
        end
      end
      if (pop_fire && pop_item.last && (emit_on || emit_off)) begin
        out_valid_r <= 1'b1;
      end else if (out_st.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire && pop_item.last && (emit_on || emit_off)) begin
      steer_r    <= emit_on ? steer_nxt : '0;
      obstacle_r <= emit_on;
    end
  end

  assign out_st.valid        = out_valid_r;
  assign out_st.steer_value  = steer_r;
  assign out_st.obstacle_now = obstacle_r;

  a_flag_flips: assert property (@(posedge clk) disable iff (!rst_n)
    pop_fire && pop_item.last && (emit_on || emit_off) |=> latched_r != $past(latched_r))
    else $error("obstacle flag did not change with an issued command");

  a_clear_is_straight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !obstacle_r |-> steer_r == '0)
    else $error("clearing command carries a nonzero steer");

endmodule

// ----- hdl/lidar_obstacle_steer_detector.sv -----
// ----------------------------------------------------------------------------
// lidar_obstacle_steer_detector
// Frame-based obstacle detection on lidar points with steering commands.
// ----------------------------------------------------------------------------
// Points enter on in_pt, one per transaction, with frame_last on the final
// point of a scan frame. A command leaves on out_st only at a frame end, and
// only when the obstacle state changes: a new obstacle gives a signed steer
// of the configured magnitude with obstacle_now set, a cleared one gives a
// zero steer with obstacle_now low.
// The front classifies each point against the configured windows in the
// cycle it is accepted. A queue of QDepth entries feeds the back, which
// folds points into the frame state and fills a single output register.
// A command turns valid once its closing point has passed the queue entry
// and the output register, and one point is taken every cycle while the
// queue has room.
// When out_st stalls, the queue absorbs points until it is full, and then
// in_pt.ready falls. Reset empties the queue, clears the frame state and the
// obstacle flag, and restores the register defaults.
// Registers sit at byte addresses 0, 4, 8, 12 and 16; the user has them
// written while no points are in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
module lidar_obstacle_steer_detector
  import lsd_pkg::*;
#(
  parameter int QDepth = QDepthDef
) (
  input  logic             clk,
  input  logic             rst_n,
  lsd_point_if.sink        in_pt,
  lsd_steer_if.source      out_st,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  lsd_cfg_t  cfg;
  logic      push_valid, push_ready;
  lsd_item_t push_item;
  logic      pop_valid, pop_ready;
  lsd_item_t pop_item;

  lsd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lsd_front u_front (
    .cfg        (cfg),
    .in_pt      (in_pt),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  lsd_fifo #(
    .QDepth (QDepth)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  lsd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .steer_magnitude (cfg.steer_magnitude),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_item        (pop_item),
    .out_st          (out_st)
  );

endmodule

// ----- verif/lidar_obstacle_steer_detector_tb.sv -----
// ----------------------------------------------------------------------------
// lidar_obstacle_steer_detector_tb
// Self-checking testbench for the lidar obstacle steering detector.
// ----------------------------------------------------------------------------
// Points are driven frame by frame on the input channel while a tracker
// follows the near-window hit, the lateral extent and the latched obstacle
// flag. Each accepted point updates the tracker, which queues the steering
// command due at the end of each frame. Every command leaving the block is
// compared field by field with the oldest queued one. A directed set of
// window, floor and tie cases runs first. Random frames follow under several
// register settings and under different sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module lidar_obstacle_steer_detector_tb;
  import lsd_pkg::*;

  localparam logic [2:0] RegSpare   = 3'd5;
  localparam int         IdleSettle = 24;
  localparam int         NumPhases  = 8;

  typedef struct packed {
    logic signed [15:0] steer;
    logic               obstacle;
  } steer_cmd_t;

  class steer_tracker;
    logic signed [15:0] near_min;
    logic signed [15:0] near_max;
    logic signed [15:0] far_min;
    logic signed [15:0] floor_z;
    logic [14:0]        mag;
    bit                 near_seen;
    bit                 latched;
    logic signed [15:0] y_hi;
    logic signed [15:0] y_lo;
    steer_cmd_t         pending_cmds[$];
    int                 n_errors;

    function new();
      near_min  = NearMinXRst;
      near_max  = NearMaxXRst;
      far_min   = FarMinXRst;
      floor_z   = FloorZRst;
      mag       = SteerMagRst;
      near_seen = 1'b0;
      latched   = 1'b0;
      y_hi      = '0;
      y_lo      = '0;
      n_errors  = 0;
    endfunction

    function void flag_error(string msg);
      n_errors++;
      if (n_errors <= 10) begin
        $display("MISMATCH at %0t: %s", $time, msg);
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        RegNearMinX: near_min = data[15:0];
        RegNearMaxX: near_max = data[15:0];
        RegFarMinX:  far_min  = data[15:0];
        RegFloorZ:   floor_z  = data[15:0];
        RegSteerMag: mag      = data[14:0];
        default: ;
      endcase
    endfunction

    function void note_point(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic last);
      steer_cmd_t cmd;
      int         hi_abs;
      int         lo_abs;
      if (z > floor_z) begin
        if (x > near_min && x < near_max) near_seen = 1'b1;
        if (x > far_min) begin
          if (y > y_hi) y_hi = y;
          if (y < y_lo) y_lo = y;
        end
      end
      if (!last) return;
      if (near_seen && !latched) begin
        hi_abs = (y_hi < 0) ? -int'(y_hi) : int'(y_hi);
        lo_abs = (y_lo < 0) ? -int'(y_lo) : int'(y_lo);
        cmd.steer    = (hi_abs > lo_abs) ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
        cmd.obstacle = 1'b1;
        latched      = 1'b1;
        pending_cmds.push_back(cmd);
      end else if (!near_seen && latched) begin
        cmd.steer    = '0;
        cmd.obstacle = 1'b0;
        latched      = 1'b0;
        pending_cmds.push_back(cmd);
      end
      near_seen = 1'b0;
      y_hi      = '0;
      y_lo      = '0;
    endfunction

    function void check_command(logic signed [15:0] steer, logic obstacle);
      steer_cmd_t exp_cmd;
      if (pending_cmds.size() == 0) begin
        flag_error($sformatf("unexpected command steer %0d obstacle_now %0b",
                             steer, obstacle));
        return;
      end
      exp_cmd = pending_cmds.pop_front();
      if (steer !== exp_cmd.steer) begin
        flag_error($sformatf("steer_value expected %0d, actual %0d", exp_cmd.steer, steer));
      end
      if (obstacle !== exp_cmd.obstacle) begin
        flag_error($sformatf("obstacle_now expected %0b, actual %0b",
                             exp_cmd.obstacle, obstacle));
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  lsd_point_if in_pt ();
  lsd_steer_if out_st ();

  steer_tracker tracker = new();

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int stall_hold = 0;
  int points_sent = 0;

  lidar_obstacle_steer_detector dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pt   (in_pt),
    .out_st  (out_st),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    out_st.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_st.valid && out_st.ready) begin
        tracker.check_command(out_st.steer_value, out_st.obstacle_now);
      end
      if (stall_hold > 0) begin
        stall_hold--;
        out_st.ready <= 1'b0;
      end else begin
        out_st.ready <= (int'($urandom_range(99)) >= rx_stall_pct);
      end
    end
  end

  function automatic logic signed [15:0] pick_in(int lo, int hi);
    if (lo > hi) return 16'($urandom);
    return 16'(lo + int'($urandom_range(hi - lo)));
  endfunction

  function automatic logic signed [15:0] pick_y();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z, logic last);
    in_pt.valid      <= 1'b1;
    in_pt.point_x    <= x;
    in_pt.point_y    <= y;
    in_pt.point_z    <= z;
    in_pt.frame_last <= last;
    do @(posedge clk); while (!in_pt.ready);
    tracker.note_point(x, y, z, last);
    points_sent++;
    while (int'($urandom_range(99)) < tx_idle_pct) begin
      in_pt.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_frame(bit hit_frame);
    int                 len;
    int                 hit_at;
    int                 kind;
    logic signed [15:0] x;
    logic signed [15:0] z;
    len    = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
    hit_at = $urandom_range(len - 1);
    for (int i = 0; i < len; i++) begin
      kind = $urandom_range(9);
      if (hit_frame && (i == hit_at || kind < 2)) begin
        x = pick_in(tracker.near_min + 1, tracker.near_max - 1);
        z = pick_in(tracker.floor_z + 1, 32767);
      end else if (kind < 6) begin
        x = pick_in(tracker.far_min + 1, 32767);
        z = pick_in(tracker.floor_z + 1, 32767);
        if (!hit_frame && x > tracker.near_min && x < tracker.near_max) begin
          z = pick_in(-32768, tracker.floor_z);
        end
      end else if (kind < 8) begin
        x = 16'($urandom);
        z = pick_in(-32768, tracker.floor_z);
      end else begin
        x = $urandom_range(1) ? tracker.near_min : tracker.near_max;
        if (hit_frame && $urandom_range(1)) x = tracker.far_min;
        z = $urandom_range(1) ? tracker.floor_z : 16'($urandom);
      end
      send_point(x, pick_y(), z, i == len - 1);
    end
  endtask

  task automatic send_noise();
    int len;
    len = $urandom_range(8, 1);
    for (int i = 0; i < len; i++) begin
      send_point(16'($urandom), 16'($urandom), 16'($urandom), $urandom_range(3) == 0);
    end
  endtask

  task automatic wait_idle();
    in_pt.valid <= 1'b0;
    while (tracker.pending_cmds.size() != 0) @(posedge clk);
    repeat (IdleSettle) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, data);
  endtask

  task automatic load_settings(int nmin, int nmax, int far, int flr, int mag);
    write_reg(RegNearMinX, {16'($urandom), 16'(nmin)});
    write_reg(RegNearMaxX, {16'($urandom), 16'(nmax)});
    write_reg(RegFarMinX, {16'($urandom), 16'(far)});
    write_reg(RegFloorZ, {16'($urandom), 16'(flr)});
    write_reg(RegSteerMag, {17'($urandom), 15'(mag)});
  endtask

  initial begin
    int quota;
    int nmin;
    in_pt.valid      <= 1'b0;
    in_pt.point_x    <= '0;
    in_pt.point_y    <= '0;
    in_pt.point_z    <= '0;
    in_pt.frame_last <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_n   <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames under the reset settings.
    send_point(16'sd1024, 16'sd0, 16'sd0, 1'b1);
    send_point(16'sd1024, 16'sd100, 16'sd0, 1'b1);
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_point(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
    send_point(16'sd4097, -16'sd32768, -16'sd127, 1'b0);
    send_point(16'sd769, 16'sd5, -16'sd127, 1'b1);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1);
    send_point(16'sd4097, -16'sd256, 16'sd0, 1'b0);
    send_point(16'sd4097, 16'sd257, 16'sd0, 1'b0);
    send_point(16'sd3839, 16'sd0, 16'sd0, 1'b1);
    send_point(16'sd768, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd3840, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd1024, 16'sd0, -16'sd128, 1'b1);
    send_point(16'sd4096, 16'sd1000, 16'sd0, 1'b0);
    send_point(16'sd4097, 16'sd300, -16'sd128, 1'b0);
    send_point(16'sd1000, -16'sd1, 16'sd0, 1'b1);
    send_point(-16'sd1, -16'sd1, -16'sd1, 1'b1);
    send_point(16'sd4097, 16'sd512, 16'sd0, 1'b0);
    send_point(16'sd4097, -16'sd512, 16'sd0, 1'b0);
    send_point(16'sd2000, 16'sd0, 16'sd0, 1'b1);
    send_point(16'sd1024, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);

    for (int phase = 0; phase < NumPhases; phase++) begin
      wait_idle();
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
        default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
      endcase
      case (phase)
        0: load_settings(NearMinXRst, NearMaxXRst, FarMinXRst, FloorZRst, SteerMagRst);
        1: load_settings(-32768, 32767, -32768, -32768, 32767);
        2: begin
          load_settings(-256, 256, 0, 0, 0);
          write_reg(RegSpare, 32'hFFFF_FFFF);
        end
        3: load_settings(32767, -32768, 32767, 32767, 1);
        default: begin
          nmin = int'($urandom_range(8192)) - 4096;
          load_settings(nmin, nmin + int'($urandom_range(6000, 2)),
                        int'($urandom_range(12000)) - 2000,
                        int'($urandom_range(2048)) - 1024, $urandom_range(32767));
        end
      endcase
      if (phase == 0) stall_hold = 80;
      quota = points_sent + ((phase == 3) ? 40 : 90);
      while (points_sent < quota) begin
        if ($urandom_range(9) == 0) begin
          send_noise();
        end else begin
          send_frame($urandom_range(1));
        end
      end
      send_frame($urandom_range(1));
    end

    in_pt.valid <= 1'b0;
    for (int w = 0; w < 5000 && tracker.pending_cmds.size() != 0; w++) @(posedge clk);
    repeat (IdleSettle) @(posedge clk);
    if (tracker.pending_cmds.size() != 0) begin
      tracker.flag_error($sformatf("%0d expected commands never arrived",
                                   tracker.pending_cmds.size()));
    end
    if (tracker.n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
